// ===== hdl/bsfb_pkg.sv =====
`timescale 1ns / 1ps

package bsfb_pkg;

  localparam int unsigned FRAME_MAX = 10;
  localparam int unsigned IDX_W     = $clog2(FRAME_MAX);
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;
  localparam int unsigned LIMIT_W   = 15;

  localparam logic [7:0] HDR_BYTE  = 8'h55;
  localparam logic [7:0] MOVE_CMD  = 8'h01;
  localparam logic [7:0] LEN_NONE  = 8'd3;
  localparam logic [7:0] LEN_BYTE  = 8'd4;
  localparam logic [7:0] LEN_WORDS = 8'd7;

  localparam logic [IDX_W-1:0] LAST_NONE  = IDX_W'(5);
  localparam logic [IDX_W-1:0] LAST_BYTE  = IDX_W'(6);
  localparam logic [IDX_W-1:0] LAST_WORDS = IDX_W'(9);

  localparam logic [LIMIT_W-1:0] PULSE_LIMIT_RST    = LIMIT_W'(1000);
  localparam logic [LIMIT_W-1:0] DURATION_LIMIT_RST = LIMIT_W'(30000);

  localparam logic [CFG_IDX_W-1:0] REG_PULSE_LIMIT    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DURATION_LIMIT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_BYTE  = 2'd1,
    OP_WORDS = 2'd2,
    OP_MOVE  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [7:0]         servo_id;
    logic [7:0]         cmd;
    logic signed [15:0] first_word;
    logic signed [15:0] second_word;
  } item_t;

  typedef struct packed {
    logic [FRAME_MAX-1:0][7:0] bytes;
    logic [IDX_W-1:0]          last_idx;
  } frame_t;

endpackage

// ===== hdl/bus_servo_frame_builder.sv =====
`timescale 1ns / 1ps
// items are registered, loaded into the serializer frame buffer and output
// from a byte register; one frame byte per cycle unless out_stall holds it,
// 6, 7 or 10 bytes per item; the next item waits in the input register
// reset: synchronous active-low rst_n empties all stages and sets the
// limits to 1000 (position) and 30000 (time)
module bus_servo_frame_builder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_op,
  input  logic [7:0]                        in_servo_id,
  input  logic [7:0]                        in_cmd,
  input  logic signed [15:0]                in_first_word,
  input  logic signed [15:0]                in_second_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        out_frame_byte,
  output logic                              out_last_byte,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsfb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsfb_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  logic [bsfb_pkg::LIMIT_W-1:0] pulse_limit_r;
  logic [bsfb_pkg::LIMIT_W-1:0] duration_limit_r;

  bsfb_pkg::item_t  item_r;
  logic             item_valid_r, item_valid_nxt;
  bsfb_pkg::frame_t frame;
  logic             buf_ready;
  logic             in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_limit_r    <= bsfb_pkg::PULSE_LIMIT_RST;
      duration_limit_r <= bsfb_pkg::DURATION_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bsfb_pkg::REG_PULSE_LIMIT) begin
        pulse_limit_r <= cfg_wdata[bsfb_pkg::LIMIT_W-1:0];
      end else if (cfg_index == bsfb_pkg::REG_DURATION_LIMIT) begin
        duration_limit_r <= cfg_wdata[bsfb_pkg::LIMIT_W-1:0];
      end
    end
  end

  // input register frees up whenever the serializer takes its frame
  assign in_stall       = item_valid_r && !buf_ready;
  assign in_take        = in_valid && !in_stall;
  assign item_valid_nxt = in_take || (item_valid_r && !buf_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op          <= bsfb_pkg::op_t'(in_op);
      item_r.servo_id    <= in_servo_id;
      item_r.cmd         <= in_cmd;
      item_r.first_word  <= in_first_word;
      item_r.second_word <= in_second_word;
    end
  end

  bsfb_builder u_builder (
    .item           (item_r),
    .pulse_limit    (pulse_limit_r),
    .duration_limit (duration_limit_r),
    .frame          (frame)
  );

  bsfb_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .load_valid     (item_valid_r),
    .load_ready     (buf_ready),
    .load_frame     (frame),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

  // a new frame always starts with the header byte
  a_frame_starts_with_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_byte |=>
      !out_valid || out_frame_byte == bsfb_pkg::HDR_BYTE)
    else $error("frame does not start with header byte");

  a_stall_needs_held_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> item_valid_r && u_serializer.load_ready == 1'b0)
    else $error("input stalled with empty input register");

  a_pulse_limit_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && cfg_index == bsfb_pkg::REG_PULSE_LIMIT |=>
      pulse_limit_r == $past(cfg_wdata[bsfb_pkg::LIMIT_W-1:0]))
    else $error("pulse limit write lost");

endmodule

// ===== hdl/bsfb_builder.sv =====
`timescale 1ns / 1ps

module bsfb_builder (
  input  bsfb_pkg::item_t                 item,
  input  logic [bsfb_pkg::LIMIT_W-1:0]    pulse_limit,
  input  logic [bsfb_pkg::LIMIT_W-1:0]    duration_limit,
  output bsfb_pkg::frame_t                frame
);

  function automatic logic [bsfb_pkg::LIMIT_W-1:0] clamp_word(
    input logic signed [15:0]            v,
    input logic [bsfb_pkg::LIMIT_W-1:0]  lim
  );
    logic [bsfb_pkg::LIMIT_W-1:0] res;
    if (v[15]) begin
      res = '0;
    end else if (v[14:0] > lim) begin
      res = lim;
    end else begin
      res = v[14:0];
    end
    return res;
  endfunction

  logic [7:0]  cmd;
  logic [15:0] w1;
  logic [15:0] w2;
  logic [7:0]  len;
  logic [7:0]  sum;

  always_comb begin
    cmd = item.cmd;
    w1  = item.first_word;
    w2  = item.second_word;
    if (item.op == bsfb_pkg::OP_MOVE) begin
      cmd = bsfb_pkg::MOVE_CMD;
      w1  = {1'b0, clamp_word(item.first_word, pulse_limit)};
      w2  = {1'b0, clamp_word(item.second_word, duration_limit)};
    end

    frame          = '0;
    frame.bytes[0] = bsfb_pkg::HDR_BYTE;
    frame.bytes[1] = bsfb_pkg::HDR_BYTE;
    frame.bytes[2] = item.servo_id;
    frame.bytes[4] = cmd;
    frame.bytes[5] = w1[7:0];
    frame.bytes[6] = w1[15:8];
    frame.bytes[7] = w2[7:0];
    frame.bytes[8] = w2[15:8];

    case (item.op)
      bsfb_pkg::OP_NONE: begin
        len            = bsfb_pkg::LEN_NONE;
        sum            = item.servo_id + len + cmd;
        frame.bytes[5] = ~sum;
        frame.last_idx = bsfb_pkg::LAST_NONE;
      end
      bsfb_pkg::OP_BYTE: begin
        len            = bsfb_pkg::LEN_BYTE;
        sum            = item.servo_id + len + cmd + w1[7:0];
        frame.bytes[6] = ~sum;
        frame.last_idx = bsfb_pkg::LAST_BYTE;
      end
      default: begin
        // two words and clamped move share the long form
        len            = bsfb_pkg::LEN_WORDS;
        sum            = item.servo_id + len + cmd + w1[7:0] + w1[15:8]
                         + w2[7:0] + w2[15:8];
        frame.bytes[9] = ~sum;
        frame.last_idx = bsfb_pkg::LAST_WORDS;
      end
    endcase
    frame.bytes[3] = len;
  end

endmodule

// ===== hdl/bsfb_serializer.sv =====
`timescale 1ns / 1ps

module bsfb_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load_valid,
  output logic             load_ready,
  input  bsfb_pkg::frame_t load_frame,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_frame_byte,
  output logic             out_last_byte
);

  bsfb_pkg::frame_t                frame_r;
  logic                            busy_r, busy_nxt;
  logic [bsfb_pkg::IDX_W-1:0]      idx_r, idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [7:0]                      out_byte_r;
  logic                            out_last_r;

  logic out_adv;
  logic pop;
  logic last_pop;
  logic load;

  assign out_adv    = !out_valid_r || !out_stall;
  assign pop        = busy_r && out_adv;
  assign last_pop   = pop && (idx_r == frame_r.last_idx);
  assign load_ready = !busy_r || last_pop;
  assign load       = load_valid && load_ready;

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_adv ? pop : out_valid_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (last_pop) begin
      busy_nxt = 1'b0;
    end else if (pop) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_r <= load_frame;
    end
    if (pop) begin
      out_byte_r <= frame_r.bytes[idx_r];
      out_last_r <= (idx_r == frame_r.last_idx);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

endmodule
